FILE: sv/thc_pkg.sv
package thc_pkg;

    localparam int NUM_STAGES  = 12;
    localparam int TEMP_STAGES = 5;
    localparam int HUM_STAGES  = NUM_STAGES - TEMP_STAGES;

    localparam int RAW_T_W     = 20;
    localparam int RAW_H_W     = 16;
    localparam int TEMP_W      = 24;
    localparam int HUM_W       = 17;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    typedef logic [NUM_STAGES-1:0] stage_en_t;
    typedef logic signed [31:0]    word_t;

    localparam word_t ROUND_T     = 32'sd128;
    localparam word_t FINE_OFFSET = 32'sd76800;
    localparam word_t ROUND_P     = 32'sd16384;
    localparam word_t Q_BIAS      = 32'sd32768;
    localparam word_t Q_OFFSET    = 32'sd2097152;
    localparam word_t ROUND_Q     = 32'sd8192;
    localparam word_t HUM_LIMIT   = 32'sd419430400;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAL_T1    = 3'd0,
        REG_CAL_T2    = 3'd1,
        REG_CAL_T3    = 3'd2,
        REG_CAL_H1    = 3'd3,
        REG_CAL_H2    = 3'd4,
        REG_CAL_H3    = 3'd5,
        REG_CAL_H4_H5 = 3'd6,
        REG_CAL_H6    = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [7:0]  h1;
        logic [15:0] h2;
        logic [7:0]  h3;
        logic [23:0] h4_h5;
        logic [7:0]  h6;
    } cal_regs_t;

endpackage

FILE: sv/thc_ctrl.sv
module thc_ctrl
    import thc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    output stage_en_t en
);

    stage_en_t valid_reg;
    stage_en_t valid_next;

    // a stage may load when it is empty or the stage after it moves
    always_comb
    begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (en[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            if (en[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    a_empty_tail_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[NUM_STAGES-1] |-> in_ready)
        else $error("pipeline refuses input with an empty output stage");

    a_out_ready_flows: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("pipeline stalls while downstream takes results");

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> valid_reg[0])
        else $error("accepted input did not enter the first stage");

endmodule

FILE: sv/thc_temp.sv
module thc_temp
    import thc_pkg::*;
(
    input  logic                    clk,
    input  stage_en_t               en,
    input  cal_regs_t               cal,
    input  logic [RAW_T_W-1:0]      raw_temperature,
    input  logic [RAW_H_W-1:0]      raw_humidity,
    output word_t                   fine_temperature,
    output logic signed [TEMP_W-1:0] temperature_centi,
    output word_t                   fine_x,
    output logic [RAW_H_W-1:0]      humidity_raw
);

    word_t a_reg, b_reg, a_next, b_next;
    word_t m1_reg, bb_reg, m1_next, bb_next;
    word_t var1_reg, m3_reg, var1_next, m3_next;
    word_t fine_reg, fine_next;
    word_t fine_out_reg, x_reg, x_next;
    word_t temp_reg, temp_next;
    word_t t2_ext, t3_ext, c_val, fine5;
    logic [RAW_H_W-1:0] hraw_reg [TEMP_STAGES];

    assign t2_ext = $signed({{16{cal.t2[15]}}, cal.t2});
    assign t3_ext = $signed({{16{cal.t3[15]}}, cal.t3});

    assign a_next = $signed({15'b0, raw_temperature[19:3]})
                  - $signed({15'b0, cal.t1, 1'b0});
    assign b_next = $signed({16'b0, raw_temperature[19:4]})
                  - $signed({16'b0, cal.t1});

    assign m1_next = a_reg * t2_ext;
    assign bb_next = b_reg * b_reg;

    assign var1_next = m1_reg >>> 11;
    assign c_val     = bb_reg >>> 12;
    assign m3_next   = c_val * t3_ext;

    assign fine_next = var1_reg + (m3_reg >>> 14);

    // fine * 5 as shift and add
    assign fine5     = fine_reg + (fine_reg <<< 2) + ROUND_T;
    assign temp_next = fine5 >>> 8;
    assign x_next    = fine_reg - FINE_OFFSET;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_reg       <= a_next;
            b_reg       <= b_next;
            hraw_reg[0] <= raw_humidity;
        end
        if (en[1])
        begin
            m1_reg <= m1_next;
            bb_reg <= bb_next;
        end
        if (en[2])
        begin
            var1_reg <= var1_next;
            m3_reg   <= m3_next;
        end
        if (en[3])
        begin
            fine_reg <= fine_next;
        end
        if (en[4])
        begin
            fine_out_reg <= fine_reg;
            temp_reg     <= temp_next;
            x_reg        <= x_next;
        end
        for (int k = 1; k < TEMP_STAGES; k++)
        begin
            if (en[k])
            begin
                hraw_reg[k] <= hraw_reg[k-1];
            end
        end
    end

    assign fine_temperature  = fine_out_reg;
    assign temperature_centi = temp_reg[TEMP_W-1:0];
    assign fine_x            = x_reg;
    assign humidity_raw      = hraw_reg[TEMP_STAGES-1];

endmodule

FILE: sv/thc_hum.sv
module thc_hum
    import thc_pkg::*;
(
    input  logic                     clk,
    input  stage_en_t                en,
    input  cal_regs_t                cal,
    input  word_t                    fine_in,
    input  logic signed [TEMP_W-1:0] temp_in,
    input  word_t                    x_in,
    input  logic [RAW_H_W-1:0]       humidity_raw,
    output word_t                    fine_temperature,
    output logic signed [TEMP_W-1:0] temperature_centi,
    output logic [HUM_W-1:0]         humidity_q10
);

    word_t h1_ext, h2_ext, h3_ext, h5_ext, h6_ext;
    word_t hx5_reg, xh6_reg, xh3_reg, pa_reg;
    word_t hx5_next, xh6_next, xh3_next, pa_next;
    word_t p1_reg, m_reg, p1_next, m_next, psum, bsum;
    word_t p2_reg, qm_reg, qm_next, q0;
    word_t v3_reg, v3_next, qsum, q_val;
    word_t v4_reg, ss_reg, ss_next, s_val;
    word_t v5_reg, t_reg, t_next;
    word_t vd, vc;
    logic [HUM_W-1:0] hum_reg, hum_next;
    word_t                    fine_pipe_reg [HUM_STAGES];
    logic signed [TEMP_W-1:0] temp_pipe_reg [HUM_STAGES];

    assign h1_ext = $signed({24'b0, cal.h1});
    assign h2_ext = $signed({{16{cal.h2[15]}}, cal.h2});
    assign h3_ext = $signed({24'b0, cal.h3});
    assign h5_ext = $signed({{20{cal.h4_h5[11]}}, cal.h4_h5[11:0]});
    assign h6_ext = $signed({{24{cal.h6[7]}}, cal.h6});

    // h4 << 20 keeps only the 12-bit word at the top
    assign hx5_next = h5_ext * x_in;
    assign xh6_next = x_in * h6_ext;
    assign xh3_next = x_in * h3_ext;
    assign pa_next  = $signed({2'b0, humidity_raw, 14'b0})
                    - $signed({cal.h4_h5[23:12], 20'b0});

    assign psum    = pa_reg - hx5_reg + ROUND_P;
    assign p1_next = psum >>> 15;
    assign bsum    = (xh3_reg >>> 11) + Q_BIAS;
    assign m_next  = (xh6_reg >>> 10) * bsum;

    assign q0      = (m_reg >>> 10) + Q_OFFSET;
    assign qm_next = q0 * h2_ext;

    assign qsum    = qm_reg + ROUND_Q;
    assign q_val   = qsum >>> 14;
    assign v3_next = p2_reg * q_val;

    assign s_val   = v3_reg >>> 15;
    assign ss_next = s_val * s_val;

    assign t_next  = (ss_reg >>> 7) * h1_ext;

    assign vd = v5_reg - (t_reg >>> 4);

    // clamp to 0..100 %
    always_comb
    begin
        if (vd[31])
        begin
            vc = '0;
        end
        else if (vd > HUM_LIMIT)
        begin
            vc = HUM_LIMIT;
        end
        else
        begin
            vc = vd;
        end
        hum_next = vc[HUM_W+11:12];
    end

    always_ff @(posedge clk)
    begin
        if (en[TEMP_STAGES])
        begin
            hx5_reg          <= hx5_next;
            xh6_reg          <= xh6_next;
            xh3_reg          <= xh3_next;
            pa_reg           <= pa_next;
            fine_pipe_reg[0] <= fine_in;
            temp_pipe_reg[0] <= temp_in;
        end
        if (en[TEMP_STAGES+1])
        begin
            p1_reg <= p1_next;
            m_reg  <= m_next;
        end
        if (en[TEMP_STAGES+2])
        begin
            p2_reg <= p1_reg;
            qm_reg <= qm_next;
        end
        if (en[TEMP_STAGES+3])
        begin
            v3_reg <= v3_next;
        end
        if (en[TEMP_STAGES+4])
        begin
            v4_reg <= v3_reg;
            ss_reg <= ss_next;
        end
        if (en[TEMP_STAGES+5])
        begin
            v5_reg <= v4_reg;
            t_reg  <= t_next;
        end
        if (en[TEMP_STAGES+6])
        begin
            hum_reg <= hum_next;
        end
        for (int k = 1; k < HUM_STAGES; k++)
        begin
            if (en[TEMP_STAGES+k])
            begin
                fine_pipe_reg[k] <= fine_pipe_reg[k-1];
                temp_pipe_reg[k] <= temp_pipe_reg[k-1];
            end
        end
    end

    assign fine_temperature  = fine_pipe_reg[HUM_STAGES-1];
    assign temperature_centi = temp_pipe_reg[HUM_STAGES-1];
    assign humidity_q10      = hum_reg;

endmodule

FILE: sv/temp_humidity_compensation.sv
// throughput: one sample pair per cycle while m_tready is high, set by the 12-stage multiply pipeline
// a stage moves whenever the stage after it is empty or moving, so bubbles close up
// reset (rst_n low, asynchronous) clears all valid bits and the calibration registers
module temp_humidity_compensation
    import thc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,  // raw_temperature, raw_humidity, pad
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,  // temperature_centi, fine_temperature, humidity_q10, pad
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cal_regs_t cal_reg;
    stage_en_t en;

    word_t                    t_fine, t_x, h_fine;
    logic signed [TEMP_W-1:0] t_temp, h_temp;
    logic [RAW_H_W-1:0]       t_hraw;
    logic [HUM_W-1:0]         h_hum;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_CAL_T1:    cal_reg.t1    <= cfg_data[15:0];
                REG_CAL_T2:    cal_reg.t2    <= cfg_data[15:0];
                REG_CAL_T3:    cal_reg.t3    <= cfg_data[15:0];
                REG_CAL_H1:    cal_reg.h1    <= cfg_data[7:0];
                REG_CAL_H2:    cal_reg.h2    <= cfg_data[15:0];
                REG_CAL_H3:    cal_reg.h3    <= cfg_data[7:0];
                REG_CAL_H4_H5: cal_reg.h4_h5 <= cfg_data;
                REG_CAL_H6:    cal_reg.h6    <= cfg_data[7:0];
                default:       cal_reg       <= cal_reg;
            endcase
        end
    end

    thc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .en        (en)
    );

    thc_temp u_temp (
        .clk               (clk),
        .en                (en),
        .cal               (cal_reg),
        .raw_temperature   (s_tdata[RAW_T_W-1:0]),
        .raw_humidity      (s_tdata[RAW_T_W+RAW_H_W-1:RAW_T_W]),
        .fine_temperature  (t_fine),
        .temperature_centi (t_temp),
        .fine_x            (t_x),
        .humidity_raw      (t_hraw)
    );

    thc_hum u_hum (
        .clk               (clk),
        .en                (en),
        .cal               (cal_reg),
        .fine_in           (t_fine),
        .temp_in           (t_temp),
        .x_in              (t_x),
        .humidity_raw      (t_hraw),
        .fine_temperature  (h_fine),
        .temperature_centi (h_temp),
        .humidity_q10      (h_hum)
    );

    assign m_tdata = {{(OUT_TDATA_W-TEMP_W-32-HUM_W){1'b0}}, h_hum, h_fine, h_temp};

endmodule

FILE: tb/sv/temp_humidity_compensation_tb.sv
module temp_humidity_compensation_tb;

    import thc_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int LONG_HOLD   = 150;

    typedef struct packed {
        logic [RAW_H_W-1:0] hum;
        logic [RAW_T_W-1:0] temp;
    } raw_sample_t;

    typedef struct packed {
        logic [HUM_W-1:0]  hum;
        logic [31:0]       fine;
        logic [TEMP_W-1:0] temp;
    } reading_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    raw_sample_t raw_samples[$];
    reading_t    expected_readings[$];
    cal_regs_t   cal_model = '0;

    logic        in_fire = 1'b0;
    logic        out_fire = 1'b0;
    logic        gapless = 1'b0;
    int unsigned send_gap = 0;
    int unsigned sink_gap = 0;
    int unsigned hold_left = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned quiet_cycles = 0;
    int unsigned mismatch_count = 0;

    temp_humidity_compensation i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
        return $signed(x) >>> n;
    endfunction

    // 32-bit wrapping fixed-point compensation, floor shifts throughout
    function automatic reading_t compensate(input logic [RAW_T_W-1:0] raw_t,
                                            input logic [RAW_H_W-1:0] raw_h);
        logic [31:0] adc_t, adc_h, t1, t2, t3, h1, h2, h3, h4, h5, h6;
        logic [31:0] a, b, var1, var2, fine, temp, x, p, q, v, s;
        reading_t    r;
        adc_t = 32'(raw_t);
        adc_h = 32'(raw_h);
        t1 = 32'(cal_model.t1);
        t2 = {{16{cal_model.t2[15]}}, cal_model.t2};
        t3 = {{16{cal_model.t3[15]}}, cal_model.t3};
        h1 = 32'(cal_model.h1);
        h2 = {{16{cal_model.h2[15]}}, cal_model.h2};
        h3 = 32'(cal_model.h3);
        h4 = {{20{cal_model.h4_h5[23]}}, cal_model.h4_h5[23:12]};
        h5 = {{20{cal_model.h4_h5[11]}}, cal_model.h4_h5[11:0]};
        h6 = {{24{cal_model.h6[7]}}, cal_model.h6};

        a    = (adc_t >> 3) - (t1 << 1);
        var1 = asr(a * t2, 11);
        b    = (adc_t >> 4) - t1;
        var2 = asr(asr(b * b, 12) * t3, 14);
        fine = var1 + var2;
        temp = asr(fine * 32'd5 + ROUND_T, 8);

        x = fine - FINE_OFFSET;
        p = asr((adc_h << 14) - (h4 << 20) - h5 * x + ROUND_P, 15);
        q = asr(asr(x * h6, 10) * (asr(x * h3, 11) + Q_BIAS), 10) + Q_OFFSET;
        q = asr(q * h2 + ROUND_Q, 14);
        v = p * q;
        s = asr(v, 15);
        v = v - asr(asr(s * s, 7) * h1, 4);
        if (v[31])
            v = '0;
        else if (v > HUM_LIMIT)
            v = HUM_LIMIT;

        r.temp = temp[TEMP_W-1:0];
        r.fine = fine;
        r.hum  = v[28:12];
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s: got 0x%08h, expected 0x%08h", what, got, want);
        mismatch_count++;
    endtask

    // sender
    always @(negedge clk)
    begin : sender
        raw_sample_t sample;
        if (!s_tvalid || in_fire)
        begin
            if (send_gap > 0 && !gapless)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (raw_samples.size() > 0)
            begin
                sample = raw_samples.pop_front();
                s_tdata  <= IN_TDATA_W'(sample);
                s_tvalid <= 1'b1;
                send_gap = gapless ? 0 : pick_gap();
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver, with an occasional long hold-off so the pipeline backs up
    always @(negedge clk)
    begin : receiver
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (gapless)
        begin
            m_tready <= 1'b1;
        end
        else if (sink_gap > 0)
        begin
            sink_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (out_fire)
                sink_gap = pick_gap();
        end
    end

    // monitor, calibration shadow, scoreboard and watchdog
    always @(posedge clk)
    begin : monitor
        reading_t want;
        reading_t got;
        logic     cfg_fire;
        in_fire  = s_tvalid && s_tready;
        out_fire = m_tvalid && m_tready;
        cfg_fire = cfg_valid && cfg_ready;

        if (cfg_fire)
        begin
            case (reg_index_t'(cfg_index))
                REG_CAL_T1:    cal_model.t1    = cfg_data[15:0];
                REG_CAL_T2:    cal_model.t2    = cfg_data[15:0];
                REG_CAL_T3:    cal_model.t3    = cfg_data[15:0];
                REG_CAL_H1:    cal_model.h1    = cfg_data[7:0];
                REG_CAL_H2:    cal_model.h2    = cfg_data[15:0];
                REG_CAL_H3:    cal_model.h3    = cfg_data[7:0];
                REG_CAL_H4_H5: cal_model.h4_h5 = cfg_data;
                REG_CAL_H6:    cal_model.h6    = cfg_data[7:0];
                default:       ;
            endcase
        end

        if (in_fire)
            expected_readings.push_back(compensate(s_tdata[RAW_T_W-1:0],
                                                   s_tdata[RAW_T_W+RAW_H_W-1:RAW_T_W]));

        if (out_fire)
        begin
            got = m_tdata[$bits(reading_t)-1:0];
            if (expected_readings.size() == 0)
            begin
                report_mismatch("unexpected transfer", 32'(got.temp), '0);
            end
            else
            begin
                want = expected_readings.pop_front();
                if (got.temp !== want.temp)
                    report_mismatch("temperature_centi", 32'(got.temp), 32'(want.temp));
                if (got.fine !== want.fine)
                    report_mismatch("fine_temperature", got.fine, want.fine);
                if (got.hum !== want.hum)
                    report_mismatch("humidity_q10", 32'(got.hum), 32'(want.hum));
            end
        end

        if (in_fire || out_fire || cfg_fire)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_cal(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_cal(input logic [CFG_DATA_W-1:0] t1, t2, t3, h1, h2, h3, h45, h6);
        write_cal(REG_CAL_T1, t1);
        write_cal(REG_CAL_T2, t2);
        write_cal(REG_CAL_T3, t3);
        write_cal(REG_CAL_H1, h1);
        write_cal(REG_CAL_H2, h2);
        write_cal(REG_CAL_H3, h3);
        write_cal(REG_CAL_H4_H5, h45);
        write_cal(REG_CAL_H6, h6);
        @(posedge clk);
    endtask

    task automatic push_sample(input logic [RAW_T_W-1:0] t, input logic [RAW_H_W-1:0] h);
        raw_sample_t sample;
        sample.temp = t;
        sample.hum  = h;
        raw_samples.push_back(sample);
    endtask

    // realistic_pct of the samples fall in the range a live sensor produces
    task automatic push_random(input int n, input int unsigned realistic_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < realistic_pct)
                push_sample(RAW_T_W'($urandom_range(380000, 660000)),
                            RAW_H_W'($urandom_range(15000, 50000)));
            else
                push_sample(RAW_T_W'($urandom), RAW_H_W'($urandom));
        end
    endtask

    task automatic wait_drained();
        while (raw_samples.size() > 0 || s_tvalid || expected_readings.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration still at its reset value of zero
        push_sample('0, '0);
        push_sample('1, '1);
        push_sample('0, '1);
        push_sample('1, '0);
        wait_drained();

        // typical factory calibration, h4 = 313 and h5 = 50
        load_cal(24'd27504, 24'd26435, 24'hFFFC18, 24'd75, 24'd362, 24'd0,
                 {12'd313, 12'd50}, 24'd30);
        push_sample(20'd519888, 16'd30000);
        push_sample('0, '0);
        push_sample('1, '1);
        push_sample('0, '1);
        push_sample('1, '0);
        push_sample(20'd519888, 16'd0);
        push_sample(20'd519888, 16'hFFFF);
        push_sample(20'd440064, 16'd25000);
        push_sample(20'hAAAAA, 16'hAAAA);
        push_sample(20'h55555, 16'h5555);
        push_sample(20'd600000, 16'd45000);
        push_sample(20'd400000, 16'd18000);
        push_random(90, 70);
        wait_drained();
        push_random(90, 70);
        hold_requests++;
        wait_drained();

        // positive extremes, no idling on either side
        gapless = 1'b1;
        load_cal(24'hFFFFFF, 24'h007FFF, 24'h007FFF, 24'h0000FF, 24'h007FFF, 24'h0000FF,
                 {12'h7FF, 12'h7FF}, 24'h00007F);
        push_random(100, 30);
        wait_drained();
        gapless = 1'b0;

        // negative extremes
        load_cal(24'h000000, 24'h008000, 24'h008000, 24'h000000, 24'h008000, 24'h000000,
                 {12'h800, 12'h800}, 24'h000080);
        push_random(100, 30);
        wait_drained();

        // random calibration, upper data bits beyond each register width set too
        for (int k = 0; k < 4; k++)
        begin
            load_cal(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                     24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
            push_random(100, 50);
            if (k == 2)
                hold_requests++;
            wait_drained();
        end

        // typical calibration with small random spread
        load_cal(24'(27504 + $urandom_range(0, 2000) - 1000),
                 24'(26435 + $urandom_range(0, 2000) - 1000),
                 24'(-1000 + $urandom_range(0, 400) - 200),
                 24'($urandom_range(0, 255)),
                 24'(362 + $urandom_range(0, 100) - 50),
                 24'($urandom_range(0, 255)),
                 {12'(313 + $urandom_range(0, 40) - 20), 12'(50 + $urandom_range(0, 20) - 10)},
                 24'(30 + $urandom_range(0, 20) - 10));
        push_random(100, 80);
        wait_drained();

        repeat (NUM_STAGES + 8) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: sim.f
sv/thc_pkg.sv
sv/thc_ctrl.sv
sv/thc_temp.sv
sv/thc_hum.sv
sv/temp_humidity_compensation.sv
tb/sv/temp_humidity_compensation_tb.sv
